// ===== hdl/unix_seconds_to_utc_datetime_assert.svh =====
// Assertion macros shared by the Unix time to UTC date converter.
`ifndef UNIX_SECONDS_TO_UTC_DATETIME_ASSERT_SVH
`define UNIX_SECONDS_TO_UTC_DATETIME_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define UTDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define UTDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/utdt_pkg.sv =====
// Types, constants and per-stage arithmetic of the Unix time to UTC date converter.
`default_nettype none

package utdt_pkg;

  // Field widths.
  localparam int EPOCH_W  = 35;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  typedef logic signed [EPOCH_W-1:0] epoch_t;
  typedef logic [YEAR_W-1:0]         year_t;
  typedef logic [MONTH_W-1:0]        month_t;
  typedef logic [DAY_W-1:0]          day_t;
  typedef logic [HOUR_W-1:0]         hour_t;
  typedef logic [MINUTE_W-1:0]       minute_t;
  typedef logic [SECOND_W-1:0]       second_t;

  // Calendar constants.
  localparam int SECS_PER_DAY   = 86400;
  localparam int SECS_PER_MIN   = 60;
  localparam int MINS_PER_HOUR  = 60;
  localparam int DAYS_SHIFT     = 719468;
  localparam int DAYS_PER_ERA   = 146097;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int YEARS_PER_ERA  = 400;
  localparam int DAYS_PER_4Y    = 1460;
  localparam int DAYS_PER_100Y  = 36524;
  localparam int YEARS_PER_CENT = 100;
  localparam int MONTH_SCALE    = 5;
  localparam int MONTH_BIAS     = 2;

  // The signed input is biased by a whole number of days so that the day
  // split works on an unsigned value. The bias is at least 2^34.
  localparam int BIAS_DAYS = 198842;
  localparam logic [35:0] SEC_BIAS = 36'(64'(BIAS_DAYS) * 64'(SECS_PER_DAY));
  localparam logic [19:0] DAY_BIAS = 20'(DAYS_SHIFT - BIAS_DAYS);

  // Reciprocal multipliers: q = (x * ceil(2^S / d)) >> S is exact for
  // x < 2^N when S = N + ceil(log2(d)).
  localparam int DAY_DIV   = 675;  // 86400 = 675 * 128
  localparam int DAY_SH    = 39;   // 29-bit dividend
  localparam logic [29:0] DAY_MUL =
    30'(((64'd1 << DAY_SH) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));
  localparam int MOD_SH    = 23;   // 17-bit second of day
  localparam logic [17:0] MOD_MUL =
    18'(((64'd1 << MOD_SH) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));
  localparam int HOUR_SH   = 17;   // 11-bit minute of day
  localparam logic [11:0] HOUR_MUL =
    12'(((64'd1 << HOUR_SH) + 64'(MINS_PER_HOUR) - 64'd1) / 64'(MINS_PER_HOUR));
  localparam int D4Y_SH    = 29;   // 18-bit day of era
  localparam logic [18:0] D4Y_MUL =
    19'(((64'd1 << D4Y_SH) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y));
  localparam int YEAR_SH   = 27;   // 18-bit adjusted day of era
  localparam logic [18:0] YEAR_MUL =
    19'(((64'd1 << YEAR_SH) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));
  localparam int MP_DIV    = 153;
  localparam int MP_SH     = 19;   // 11-bit scaled day of year
  localparam logic [11:0] MP_MUL =
    12'(((64'd1 << MP_SH) + 64'(MP_DIV) - 64'd1) / 64'(MP_DIV));

  // Pipeline stage numbers.
  localparam int STG_BIAS   = 0;
  localparam int STG_DAYDIV = 1;
  localparam int STG_SOD    = 2;
  localparam int STG_MOD    = 3;
  localparam int STG_DOE    = 4;
  localparam int STG_CENT   = 5;
  localparam int STG_ADJ    = 6;
  localparam int STG_YOE    = 7;
  localparam int STG_BASE   = 8;
  localparam int STG_DOY    = 9;
  localparam int STG_MP     = 10;
  localparam int STG_DATE   = 11;
  localparam int STAGES     = 12;

  // Everything one timestamp carries down the pipeline.
  typedef struct packed {
    logic [34:0] secs;    // raw input
    logic [35:0] u;       // biased seconds
    logic [18:0] q;       // biased day count
    logic [16:0] sod;     // second of day
    logic [19:0] z;       // days since 0000-03-01
    logic [10:0] mod;     // minute of day
    logic [2:0]  era;
    second_t     sec;
    hour_t       hour;
    minute_t     minute;
    logic [17:0] doe;     // day of era
    logic [6:0]  d4y;     // doe / 1460
    logic [2:0]  c100y;   // doe / 36524
    logic        cera;    // doe / 146096
    logic [17:0] t;       // adjusted day of era
    logic [8:0]  yoe;     // year of era
    logic [17:0] base;    // first day of the year within the era
    logic [8:0]  doy;     // day of March-based year
    logic [3:0]  mp;      // March-based month
    year_t       year;
    month_t      month;
    day_t        day;
  } work_t;

  // Day of the March-based year on which month mp starts.
  function automatic logic [8:0] mp_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Work done between register idx-1 and register idx.
  function automatic work_t utdt_stage(input int idx, input work_t w);
    work_t       r;
    logic [58:0] p_day;
    logic [35:0] p_sod;
    logic [34:0] p_mod;
    logic [22:0] p_hr;
    logic [36:0] p_d4y;
    logic [36:0] p_yoe;
    logic [10:0] x_mp;
    logic [22:0] p_mp;
    logic [2:0]  era_n;
    logic [2:0]  c100_n;
    logic [1:0]  cent_n;
    logic [3:0]  mon;
    r      = w;
    era_n  = '0;
    c100_n = '0;
    cent_n = '0;
    mon    = '0;
    case (idx)
      STG_BIAS: begin
        r.u = {w.secs[34], w.secs} + SEC_BIAS;
      end
      STG_DAYDIV: begin
        p_day = 59'(w.u[35:7]) * 59'(DAY_MUL);
        r.q   = p_day[57:39];
      end
      STG_SOD: begin
        p_sod = 36'(w.q) * 36'(SECS_PER_DAY);
        r.sod = w.u[16:0] - p_sod[16:0];
        r.z   = 20'(w.q) + DAY_BIAS;
      end
      STG_MOD: begin
        p_mod = 35'(w.sod) * 35'(MOD_MUL);
        r.mod = p_mod[33:23];
        for (int k = 1; k <= 7; k++) begin
          if (w.z >= 20'(k * DAYS_PER_ERA)) era_n = era_n + 3'd1;
        end
        r.era = era_n;
      end
      STG_DOE: begin
        r.sec  = 6'(w.sod - 17'(w.mod) * 17'(SECS_PER_MIN));
        p_hr   = 23'(w.mod) * 23'(HOUR_MUL);
        r.hour = p_hr[21:17];
        r.doe  = 18'(w.z - 20'(w.era) * 20'(DAYS_PER_ERA));
      end
      STG_CENT: begin
        r.minute = 6'(w.mod - 11'(w.hour) * 11'(MINS_PER_HOUR));
        p_d4y    = 37'(w.doe) * 37'(D4Y_MUL);
        r.d4y    = p_d4y[35:29];
        for (int k = 1; k <= 4; k++) begin
          if (w.doe >= 18'(k * DAYS_PER_100Y)) c100_n = c100_n + 3'd1;
        end
        r.c100y = c100_n;
        r.cera  = (w.doe >= 18'(DAYS_PER_ERA - 1));
      end
      STG_ADJ: begin
        r.t = w.doe - 18'(w.d4y) + 18'(w.c100y) - 18'(w.cera);
      end
      STG_YOE: begin
        p_yoe = 37'(w.t) * 37'(YEAR_MUL);
        r.yoe = p_yoe[35:27];
      end
      STG_BASE: begin
        for (int k = 1; k <= 3; k++) begin
          if (w.yoe >= 9'(k * YEARS_PER_CENT)) cent_n = cent_n + 2'd1;
        end
        r.base = 18'(w.yoe) * 18'(DAYS_PER_YEAR) + 18'(w.yoe[8:2]) - 18'(cent_n);
      end
      STG_DOY: begin
        r.doy = 9'(w.doe - w.base);
      end
      STG_MP: begin
        x_mp = 11'(w.doy) * 11'(MONTH_SCALE) + 11'(MONTH_BIAS);
        p_mp = 23'(x_mp) * 23'(MP_MUL);
        r.mp = p_mp[22:19];
      end
      STG_DATE: begin
        r.day   = 5'(w.doy - mp_start(w.mp) + 9'd1);
        mon     = (w.mp < 4'd10) ? w.mp + 4'd3 : w.mp - 4'd9;
        r.month = mon;
        r.year  = 12'(w.yoe) + 12'(w.era) * 12'(YEARS_PER_ERA)
                + 12'(mon <= 4'd2);
      end
      default: begin
        r = w;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/utdt_if.sv =====
// Valid/ready channel interfaces for timestamps in and calendar results out.
`default_nettype none

interface utdt_in_if import utdt_pkg::*;;
  logic   valid;
  logic   ready;
  epoch_t epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface utdt_out_if import utdt_pkg::*;;
  logic    valid;
  logic    ready;
  year_t   year;
  month_t  month;
  day_t    day;
  hour_t   hour;
  minute_t minute;
  second_t second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

// ===== hdl/unix_seconds_to_utc_datetime.sv =====
// Top level: pipelined conversion of signed Unix seconds to a UTC calendar date and time.
//
//   Channel   Dir   Payload                                   Handshake
//   in_ch     in    epoch_seconds (35 bit, signed)            valid / ready
//   out_ch    out   year, month, day, hour, minute, second    valid / ready
//
// One transfer can be taken on in_ch in every cycle unless out_ch stalls a full chain.
// Each result is registered in every stage of the chain, from the bias through the
// day split to the date, before it is offered on out_ch.
// Reset (rst_n low, synchronous) empties every stage; no payload is cleared.
// When out_ch is stalled the full stages hold, while empty stages ahead of
// them keep filling, so in_ch.ready drops only once the whole chain is full.
`default_nettype none

`include "unix_seconds_to_utc_datetime_assert.svh"

module unix_seconds_to_utc_datetime import utdt_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  utdt_in_if.sink         in_ch,
  utdt_out_if.source      out_ch
);

  localparam int NSTG = STAGES;

  // One valid bit per stage; a stage may load whenever it is empty or the
  // stage after it is loading too.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] up_vld;

  work_t in_work;
  work_t stg_r   [NSTG];
  work_t stg_nxt [NSTG];

  // The raw timestamp enters the first stage; every other field is filled
  // in further down the chain.
  always_comb begin
    in_work      = '0;
    in_work.secs = in_ch.epoch_seconds;
  end

  // Ready travels backward from the output register to the input.
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int g = NSTG - 2; g >= 0; g--) begin
      rdy[g] = !vld_r[g] || rdy[g+1];
    end
  end

  assign up_vld  = {vld_r[NSTG-2:0], in_ch.valid};
  assign vld_nxt = (vld_r & ~rdy) | (up_vld & rdy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Each stage applies its slice of the arithmetic (see utdt_stage) and
  // registers the whole work record.
  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign stg_nxt[g] = utdt_stage(g, in_work);
    end else begin : g_rest
      assign stg_nxt[g] = utdt_stage(g, stg_r[g-1]);
    end

    always_ff @(posedge clk) begin
      if (rdy[g] && up_vld[g]) begin
        stg_r[g] <= stg_nxt[g];
      end
    end
  end

  // The last stage is the result register.
  assign in_ch.ready   = rdy[0];
  assign out_ch.valid  = vld_r[NSTG-1];
  assign out_ch.year   = stg_r[NSTG-1].year;
  assign out_ch.month  = stg_r[NSTG-1].month;
  assign out_ch.day    = stg_r[NSTG-1].day;
  assign out_ch.hour   = stg_r[NSTG-1].hour;
  assign out_ch.minute = stg_r[NSTG-1].minute;
  assign out_ch.second = stg_r[NSTG-1].sec;

  // Terms watched by the checks below.
  logic in_xfer;
  logic fields_ok;
  logic year_ok;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign fields_ok = out_ch.month >= 4'd1 && out_ch.month <= 4'd12
                  && out_ch.day >= 5'd1 && out_ch.day <= 5'd31
                  && out_ch.hour <= 5'd23 && out_ch.minute <= 6'd59
                  && out_ch.second <= 6'd59;
  assign year_ok   = out_ch.year >= 12'd1425 && out_ch.year <= 12'd2515;

  // An accepted timestamp always lands in the first stage.
  `UTDT_ASSERT_NEXT(a_accept_enters, in_xfer, vld_r[0], "accepted timestamp lost at the entry")

  // The reciprocal divisions must leave every calendar field in its range.
  `UTDT_ASSERT_NOW(a_fields_in_range, out_ch.valid, fields_ok, "calendar field out of range")

  // Every 35-bit instant maps into this span of years.
  `UTDT_ASSERT_NOW(a_year_in_range, out_ch.valid, year_ok, "year outside the reachable span")

endmodule

`default_nettype wire

// ===== verif/tb_unix_seconds_to_utc_datetime.sv =====
// Self-checking bench for the Unix seconds to UTC calendar converter.
`default_nettype none

module tb_unix_seconds_to_utc_datetime;
  import utdt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Expected calendar fields of one converted timestamp.
  typedef struct packed {
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
    second_t second;
  } civil_t;

  // Months of the March-based year use the 153 days per 5 months rule.
  localparam int DAYS_PER_5M = 153;
  localparam int MONTHS_IN_5 = 5;
  localparam int SECS_PER_HOUR = SECS_PER_MIN * MINS_PER_HOUR;
  localparam int IDLE_PCT = 24;
  // Count of days on each side of the epoch that stay inside the input range.
  localparam longint DAY_SPAN = 198841;
  localparam longint EPOCH_MAX = (longint'(1) <<< (EPOCH_W - 1)) - 1;
  localparam longint EPOCH_MIN = -(longint'(1) <<< (EPOCH_W - 1));

  logic clk;
  logic rst_n;

  utdt_in_if  in_ch ();
  utdt_out_if out_ch ();

  unix_seconds_to_utc_datetime DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Timestamps waiting to be offered, and calendar results waiting to arrive.
  epoch_t stamp_q[$];
  civil_t civil_q[$];

  logic in_fire;
  logic calm;
  int   n_taken;
  bit   failed;

  always #10 clk = ~clk;

  // Division that rounds toward minus infinity; SystemVerilog truncates.
  function automatic longint div_floor(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  // Converts one timestamp to its calendar date and time of day.
  function automatic civil_t civil_from_epoch(epoch_t e);
    civil_t c;
    longint secs, days, sod, z, era, doe, yoe, doy, mp, mon, yr;
    secs = longint'(e);
    days = div_floor(secs, SECS_PER_DAY);
    sod  = secs - days * SECS_PER_DAY;
    // Shift the day count so that day 0 is 0000-03-01 and split it into eras.
    z    = days + DAYS_SHIFT;
    era  = div_floor(z, DAYS_PER_ERA);
    doe  = z - era * DAYS_PER_ERA;
    yoe  = (doe - doe / DAYS_PER_4Y + doe / DAYS_PER_100Y
            - doe / (DAYS_PER_ERA - 1)) / DAYS_PER_YEAR;
    doy  = doe - (DAYS_PER_YEAR * yoe + yoe / 4 - yoe / YEARS_PER_CENT);
    mp   = (MONTHS_IN_5 * doy + MONTH_BIAS) / DAYS_PER_5M;
    mon  = (mp < 10) ? mp + 3 : mp - 9;
    // January and February belong to the following civil year.
    yr   = yoe + era * YEARS_PER_ERA + ((mon <= 2) ? 1 : 0);
    c.year   = year_t'(yr);
    c.month  = month_t'(mon);
    c.day    = day_t'(doy - (DAYS_PER_5M * mp + MONTH_BIAS) / MONTHS_IN_5 + 1);
    c.hour   = hour_t'(sod / SECS_PER_HOUR);
    c.minute = minute_t'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
    c.second = second_t'(sod % SECS_PER_MIN);
    return c;
  endfunction

  // Random timestamp: full-range patterns, day boundaries and the two ends of the
  // range in equal shares; carries and borrows are most likely to break at the last two.
  function automatic epoch_t pick_stamp();
    longint v;
    case ($urandom_range(3))
      0: begin
        v = {$urandom, $urandom};
      end
      1: begin
        v = (longint'($urandom_range(2 * DAY_SPAN - 1)) - DAY_SPAN) * SECS_PER_DAY
          + longint'($urandom_range(2)) - 1;
      end
      2: begin
        v = EPOCH_MAX - longint'($urandom_range(3 * SECS_PER_DAY));
      end
      default: begin
        v = EPOCH_MIN + longint'($urandom_range(3 * SECS_PER_DAY));
      end
    endcase
    return epoch_t'(v);
  endfunction

  task automatic report_field(string fname, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, fname, want, got);
    failed = 1'b1;
  endtask

  // Input side bookkeeping: every transfer on in_ch is predicted at once.
  // The idle-free stretch covers a window of accepted timestamps.
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      civil_q.push_back(civil_from_epoch(in_ch.epoch_seconds));
      n_taken <= n_taken + 1;
      calm <= (n_taken >= 500 && n_taken < 700);
    end
  end

  // Driver: inputs change on the falling edge. A new timestamp is offered
  // only when the previous one went through or nothing is on offer, and the
  // sender skips about a quarter of its chances outside the calm stretch.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_fire) begin
        if (stamp_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid         <= 1'b1;
          in_ch.epoch_seconds <= stamp_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    civil_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (civil_q.size() == 0) begin
        $display("%0t: result with none expected, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $realtime, out_ch.year, out_ch.month, out_ch.day,
                 out_ch.hour, out_ch.minute, out_ch.second);
        failed = 1'b1;
      end else begin
        want = civil_q.pop_front();
        if (out_ch.year != want.year) report_field("year", want.year, out_ch.year);
        if (out_ch.month != want.month) report_field("month", want.month, out_ch.month);
        if (out_ch.day != want.day) report_field("day", want.day, out_ch.day);
        if (out_ch.hour != want.hour) report_field("hour", want.hour, out_ch.hour);
        if (out_ch.minute != want.minute) begin
          report_field("minute", want.minute, out_ch.minute);
        end
        if (out_ch.second != want.second) begin
          report_field("second", want.second, out_ch.second);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    longint directed[$];
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.epoch_seconds = '0;
    out_ch.ready        = 1'b0;
    in_fire             = 1'b0;
    calm                = 1'b0;
    n_taken             = 0;
    failed              = 1'b0;

    // The epoch itself, the last second before it, and whole-day edges on
    // both sides, where the floor split must borrow from the day count.
    directed = '{0, -1, 1, 86399, 86400, -86399, -86400, -86401,
                 // Last day of February and first of March in a leap
                 // century year, in century years that are not leap, and at
                 // the start of a 400-year era.
                 951868799, 951868800, -64'sd2203891201, -64'sd2203891200,
                 64'sd4107542399, 64'sd4107542400, -64'sd11670912001,
                 -64'sd11670912000,
                 // New year's eve into new year.
                 946684799, 946684800,
                 // The ends of the input range and alternating bit patterns.
                 EPOCH_MAX, EPOCH_MIN, EPOCH_MAX - 86400, EPOCH_MIN + 86400,
                 longint'(35'h2_AAAA_AAAA) - (longint'(1) <<< EPOCH_W),
                 longint'(35'h5_5555_5555)};
    foreach (directed[k]) stamp_q.push_back(epoch_t'(directed[k]));
    for (int k = 0; k < 100; k++) stamp_q.push_back(pick_stamp());

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Hold the sender back once until the pipeline has drained completely.
    while (stamp_q.size() != 0 || in_ch.valid || civil_q.size() != 0) begin
      @(posedge clk);
    end
    for (int k = 0; k < 1030; k++) stamp_q.push_back(pick_stamp());

    while (stamp_q.size() != 0 || in_ch.valid || civil_q.size() != 0) begin
      @(posedge clk);
    end
    // Run on after the twelve-stage pipeline has drained to catch stray results.
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/utdt_pkg.sv
hdl/utdt_if.sv
hdl/unix_seconds_to_utc_datetime.sv
verif/tb_unix_seconds_to_utc_datetime.sv
